>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/ptl_pkg.sv
// shared types, constants and the calibration rom of the pt1000 linearizer
`default_nettype none

package ptl_pkg;

    localparam int ROM_ROWS = 31;
    localparam int IDX_W    = 5;
    localparam int VIN_W    = 23;
    localparam int UV_W     = 22;
    localparam int RES_W    = 18;
    localparam int FLAG_W   = 2;
    localparam int DR_W     = 19;
    localparam int DVV_W    = 24;
    localparam int PROD_W   = 36;
    localparam int DV_W     = 22;
    localparam int SUM_W    = 38;

    localparam logic [FLAG_W-1:0] FLAG_INSIDE = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_BELOW  = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_ABOVE  = 2'd2;

    localparam logic [RES_W-1:0] R_MIN_CENTIOHM = 18'd10000;
    localparam logic [RES_W-1:0] R_MAX_CENTIOHM = 18'd200000;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DV_W-1:0]   divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // table voltage in millivolts
    function automatic int rom_mv(input logic [IDX_W-1:0] idx);
        int mv;
        case (idx)
            5'd0:  mv = 15;
            5'd1:  mv = 145;
            5'd2:  mv = 268;
            5'd3:  mv = 392;
            5'd4:  mv = 514;
            5'd5:  mv = 634;
            5'd6:  mv = 754;
            5'd7:  mv = 869;
            5'd8:  mv = 986;
            5'd9:  mv = 1098;
            5'd10: mv = 1216;
            5'd11: mv = 1322;
            5'd12: mv = 1430;
            5'd13: mv = 1540;
            5'd14: mv = 1650;
            5'd15: mv = 1753;
            5'd16: mv = 1818;
            5'd17: mv = 1859;
            5'd18: mv = 1900;
            5'd19: mv = 1941;
            5'd20: mv = 1981;
            5'd21: mv = 2030;
            5'd22: mv = 2070;
            5'd23: mv = 2114;
            5'd24: mv = 2159;
            5'd25: mv = 2201;
            5'd26: mv = 2247;
            5'd27: mv = 2288;
            5'd28: mv = 2330;
            5'd29: mv = 2380;
            5'd30: mv = 2426;
            default: mv = 0;
        endcase
        return mv;
    endfunction

    // table resistance in 0.1 ohm
    function automatic int rom_dohm(input logic [IDX_W-1:0] idx);
        int r;
        case (idx)
            5'd0:  r = 1852;
            5'd1:  r = 2283;
            5'd2:  r = 2710;
            5'd3:  r = 3134;
            5'd4:  r = 3554;
            5'd5:  r = 3972;
            5'd6:  r = 4388;
            5'd7:  r = 4800;
            5'd8:  r = 5211;
            5'd9:  r = 5619;
            5'd10: r = 6026;
            5'd11: r = 6430;
            5'd12: r = 6833;
            5'd13: r = 7233;
            5'd14: r = 7633;
            5'd15: r = 8031;
            5'd16: r = 8427;
            5'd17: r = 8822;
            5'd18: r = 9216;
            5'd19: r = 9609;
            5'd20: r = 10000;
            5'd21: r = 10390;
            5'd22: r = 10779;
            5'd23: r = 11167;
            5'd24: r = 11554;
            5'd25: r = 11940;
            5'd26: r = 12324;
            5'd27: r = 12708;
            5'd28: r = 13090;
            5'd29: r = 13471;
            5'd30: r = 13851;
            default: r = 0;
        endcase
        return r;
    endfunction

    // table voltage in microvolts
    function automatic logic [UV_W-1:0] rom_uv(input logic [IDX_W-1:0] idx);
        return UV_W'(rom_mv(idx) * 1000);
    endfunction

    // table resistance in centiohm
    function automatic logic [RES_W-1:0] rom_cohm(input logic [IDX_W-1:0] idx);
        return RES_W'(rom_dohm(idx) * 10);
    endfunction

endpackage

`default_nettype wire

>>> design/ptl_divider.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module ptl_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptl_pkg::div_ctrl_t ctrl,
    output ptl_pkg::div_stat_t     stat,
    output logic [ptl_pkg::PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ptl_pkg::PROD_W + 1);

    logic [ptl_pkg::PROD_W-1:0] shift_reg, shift_next;
    logic [ptl_pkg::DV_W-1:0]   rem_reg, rem_next;
    logic [ptl_pkg::DV_W-1:0]   divisor_reg, divisor_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ptl_pkg::DV_W:0]     trial;
    logic                       fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, shift_reg[ptl_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (ctrl.start && !busy_reg)
        begin
            shift_next   = ctrl.dividend;
            rem_next     = '0;
            divisor_next = ctrl.divisor;
            count_next   = CNT_W'(ptl_pkg::PROD_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[ptl_pkg::PROD_W-2:0], fits};
            rem_next   = fits ? ptl_pkg::DV_W'(trial - {1'b0, divisor_reg})
                              : trial[ptl_pkg::DV_W-1:0];
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = shift_reg;

endmodule

`default_nettype wire

>>> design/pt1000_piecewise_linearizer_core.sv
// top level of the pt1000 piecewise linear voltage to resistance converter
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------
// input   | in        | in_valid / in_stall | voltage_uv (23 b, microvolts)
// output  | out       | out_valid/out_stall | resistance_centiohm (18 b), range_flag
//
// steps from acceptance to result: classify, up to five search steps and an exit step
// inside the table only, rom read, multiply, divider start, a divider pass over the 36
// dividend bits (one quotient bit each), a wait step that sees done and one finish step
// in_stall stays high until the finish step, so no new item is taken before that step
// the result waits in an output register, so a new item is taken while it is stalled
// reset is asynchronous, active low, and clears the sequencer and the output valid
`default_nettype none

module pt1000_piecewise_linearizer_core #(
    parameter int TABLE_POINTS = 31
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ptl_pkg::VIN_W-1:0]   voltage_uv,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ptl_pkg::RES_W-1:0]        resistance_centiohm,
    output logic [ptl_pkg::FLAG_W-1:0]       range_flag
);

    // number of rom points in use, limited to the rom size and to at least two
    localparam int N_USED = (TABLE_POINTS > ptl_pkg::ROM_ROWS) ? ptl_pkg::ROM_ROWS :
                            ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam logic [ptl_pkg::IDX_W-1:0] IDX_LAST = ptl_pkg::IDX_W'(N_USED - 1);
    localparam logic [ptl_pkg::IDX_W-1:0] IDX_PREV = ptl_pkg::IDX_W'(N_USED - 2);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLASS  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_START  = 3'd5;
    localparam logic [2:0] ST_WAIT   = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // item payload and working registers
    logic [ptl_pkg::VIN_W-1:0]  v_reg, v_next;
    logic [ptl_pkg::IDX_W-1:0]  lo_reg, lo_next;
    logic [ptl_pkg::IDX_W-1:0]  hi_reg, hi_next;
    logic [ptl_pkg::FLAG_W-1:0] flag_reg, flag_next;
    logic [ptl_pkg::RES_W-1:0]  ra_reg, ra_next;
    logic signed [ptl_pkg::DR_W-1:0]  dr_reg, dr_next;
    logic signed [ptl_pkg::DVV_W-1:0] dvv_reg, dvv_next;
    logic [ptl_pkg::DV_W-1:0]   dv_reg, dv_next;
    logic                       dv_zero_reg, dv_zero_next;
    logic [ptl_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic [ptl_pkg::RES_W-1:0]  res_reg, res_next;
    logic [ptl_pkg::FLAG_W-1:0] oflag_reg, oflag_next;

    // search and segment helpers
    logic [ptl_pkg::IDX_W-1:0]  span;
    logic [ptl_pkg::IDX_W-1:0]  mid;
    logic [ptl_pkg::IDX_W-1:0]  lo_up;
    logic [ptl_pkg::UV_W-1:0]   va;
    logic [ptl_pkg::UV_W-1:0]   vb;
    logic [ptl_pkg::RES_W-1:0]  rb;
    logic signed [ptl_pkg::DR_W+ptl_pkg::DVV_W-1:0] prod_full;
    logic [ptl_pkg::DR_W+ptl_pkg::DVV_W-1:0]        prod_abs;

    // finish step helpers
    logic [ptl_pkg::PROD_W-1:0]       q_eff;
    logic signed [ptl_pkg::SUM_W-1:0] sum;
    logic signed [ptl_pkg::SUM_W-1:0] sum_clamped;
    logic                             out_free;

    ptl_pkg::div_ctrl_t         div_ctrl;
    ptl_pkg::div_stat_t         div_stat;
    logic [ptl_pkg::PROD_W-1:0] div_q;

    ptl_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign span  = hi_reg - lo_reg;
    assign mid   = lo_reg + (span >> 1);
    assign lo_up = lo_reg + ptl_pkg::IDX_W'(1);
    assign va    = ptl_pkg::rom_uv(lo_reg);
    assign vb    = ptl_pkg::rom_uv(lo_up);
    assign rb    = ptl_pkg::rom_cohm(lo_up);

    // single multiplier: resistance step times voltage offset
    assign prod_full = dr_reg * dvv_reg;
    assign prod_abs  = prod_full[ptl_pkg::DR_W+ptl_pkg::DVV_W-1] ?
                       ($unsigned(-prod_full)) : $unsigned(prod_full);

    assign div_ctrl.start    = (state_reg == ST_START) && !div_stat.busy;
    assign div_ctrl.dividend = prod_reg;
    assign div_ctrl.divisor  = dv_reg;

    // quotient truncates toward zero, sign applied afterwards
    assign q_eff = dv_zero_reg ? '0 : div_q;
    assign sum   = neg_reg ?
                   ($signed({{(ptl_pkg::SUM_W-ptl_pkg::RES_W){1'b0}}, ra_reg})
                    - $signed({2'b00, q_eff})) :
                   ($signed({{(ptl_pkg::SUM_W-ptl_pkg::RES_W){1'b0}}, ra_reg})
                    + $signed({2'b00, q_eff}));

    // end-of-table clamps
    always_comb
    begin
        sum_clamped = sum;
        if ((flag_reg == ptl_pkg::FLAG_BELOW)
            && (sum < $signed(ptl_pkg::SUM_W'(ptl_pkg::R_MIN_CENTIOHM))))
        begin
            sum_clamped = ptl_pkg::SUM_W'(ptl_pkg::R_MIN_CENTIOHM);
        end
        else if ((flag_reg == ptl_pkg::FLAG_ABOVE)
            && (sum > $signed(ptl_pkg::SUM_W'(ptl_pkg::R_MAX_CENTIOHM))))
        begin
            sum_clamped = ptl_pkg::SUM_W'(ptl_pkg::R_MAX_CENTIOHM);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        flag_next      = flag_reg;
        ra_next        = ra_reg;
        dr_next        = dr_reg;
        dvv_next       = dvv_reg;
        dv_next        = dv_reg;
        dv_zero_next   = dv_zero_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        oflag_next     = oflag_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = voltage_uv;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                // an input equal to an end point counts as outside
                if (v_reg <= {1'b0, ptl_pkg::rom_uv('0)})
                begin
                    lo_next    = '0;
                    flag_next  = ptl_pkg::FLAG_BELOW;
                    state_next = ST_LOAD;
                end
                else if (v_reg >= {1'b0, ptl_pkg::rom_uv(IDX_LAST)})
                begin
                    lo_next    = IDX_PREV;
                    flag_next  = ptl_pkg::FLAG_ABOVE;
                    state_next = ST_LOAD;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = IDX_LAST;
                    flag_next  = ptl_pkg::FLAG_INSIDE;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (span > ptl_pkg::IDX_W'(1))
                begin
                    if (v_reg < {1'b0, ptl_pkg::rom_uv(mid)})
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid;
                    end
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ra_next      = ptl_pkg::rom_cohm(lo_reg);
                dr_next      = $signed({1'b0, rb}) - $signed({1'b0, ptl_pkg::rom_cohm(lo_reg)});
                dvv_next     = $signed({1'b0, v_reg}) - $signed({2'b00, va});
                dv_next      = vb - va;
                dv_zero_next = (vb == va);
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = prod_abs[ptl_pkg::PROD_W-1:0];
                neg_next   = prod_full[ptl_pkg::DR_W+ptl_pkg::DVV_W-1];
                state_next = ST_START;
            end
            ST_START:
            begin
                if (!div_stat.busy)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the finished item until the output register is free
                if (out_free)
                begin
                    if (sum_clamped < 0)
                    begin
                        res_next = '0;
                    end
                    else if (sum_clamped > $signed({{(ptl_pkg::SUM_W-ptl_pkg::RES_W){1'b0}},
                                                    {ptl_pkg::RES_W{1'b1}}}))
                    begin
                        res_next = '1;
                    end
                    else
                    begin
                        res_next = sum_clamped[ptl_pkg::RES_W-1:0];
                    end
                    oflag_next     = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        flag_reg    <= flag_next;
        ra_reg      <= ra_next;
        dr_reg      <= dr_next;
        dvv_reg     <= dvv_next;
        dv_reg      <= dv_next;
        dv_zero_reg <= dv_zero_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
        oflag_reg   <= oflag_next;
    end

    assign in_stall            = (state_reg != ST_IDLE);
    assign out_valid           = out_valid_reg;
    assign resistance_centiohm = res_reg;
    assign range_flag          = oflag_reg;

endmodule

`default_nettype wire

>>> design/ptl_checker.sv
// port-level checks of the linearizer and their binding to the top level
`default_nettype none
`include "assert_macros.svh"

module ptl_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [ptl_pkg::RES_W-1:0]   resistance_centiohm,
    input wire logic [ptl_pkg::FLAG_W-1:0]  range_flag
);

    // stalled result holds its payload
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(resistance_centiohm) && $stable(range_flag))

    // an accepted item keeps the input side busy
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // every result stays inside the clamp window
    `CHK_IMPLIES(a_res_window, clk, rst_n, out_valid, (resistance_centiohm >= ptl_pkg::R_MIN_CENTIOHM) && (resistance_centiohm <= ptl_pkg::R_MAX_CENTIOHM))

    // below the table the result never exceeds the first point
    `CHK_IMPLIES(a_below_bound, clk, rst_n, out_valid && (range_flag == ptl_pkg::FLAG_BELOW), resistance_centiohm <= ptl_pkg::rom_cohm('0))

    // above the table the result never drops under the first point
    `CHK_IMPLIES(a_above_bound, clk, rst_n, out_valid && (range_flag == ptl_pkg::FLAG_ABOVE), resistance_centiohm >= ptl_pkg::rom_cohm('0))

endmodule

bind pt1000_piecewise_linearizer_core ptl_checker u_ptl_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .resistance_centiohm (resistance_centiohm),
    .range_flag          (range_flag)
);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the pt1000 piecewise linearizer core
module tb_top;

    localparam int N_POINTS    = 31;
    localparam int DRAIN_WAIT  = 100;
    localparam int PRINT_LIMIT = 100;
    localparam int N_RANDOM    = 1100;

    typedef struct {
        logic [ptl_pkg::RES_W-1:0]  res;
        logic [ptl_pkg::FLAG_W-1:0] flag;
    } reading_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [ptl_pkg::VIN_W-1:0]    voltage_uv = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ptl_pkg::RES_W-1:0]    resistance_centiohm;
    logic [ptl_pkg::FLAG_W-1:0]   range_flag;

    // calibration points: millivolts and 0.1 ohm
    int pt_mv [0:30] = '{
        15, 145, 268, 392, 514, 634, 754, 869, 986, 1098, 1216, 1322, 1430, 1540, 1650,
        1753, 1818, 1859, 1900, 1941, 1981, 2030, 2070, 2114, 2159, 2201, 2247, 2288,
        2330, 2380, 2426};
    int pt_dohm [0:30] = '{
        1852, 2283, 2710, 3134, 3554, 3972, 4388, 4800, 5211, 5619, 6026, 6430, 6833,
        7233, 7633, 8031, 8427, 8822, 9216, 9609, 10000, 10390, 10779, 11167, 11554,
        11940, 12324, 12708, 13090, 13471, 13851};

    logic [ptl_pkg::VIN_W-1:0] pending_voltages[$];
    reading_t                  expected_readings[$];

    int err_cnt      = 0;
    int in_acc_cnt   = 0;
    int got_cnt      = 0;
    int drv_seen_cnt = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int hold_idx     = 0;
    int hold_marks [0:1] = '{120, 640};

    pt1000_piecewise_linearizer_core #(
        .TABLE_POINTS(N_POINTS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .voltage_uv          (voltage_uv),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .resistance_centiohm (resistance_centiohm),
        .range_flag          (range_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // straight line through two calibration points, in centiohm, truncating division
    function automatic longint seg_line(input int a, input int b, input longint v);
        longint va, vb, ra, rb, dv;
        va = longint'(pt_mv[a]) * 1000;
        vb = longint'(pt_mv[b]) * 1000;
        ra = longint'(pt_dohm[a]) * 10;
        rb = longint'(pt_dohm[b]) * 10;
        dv = vb - va;
        if (dv == 0)
            return ra;
        return ra + ((rb - ra) * (v - va)) / dv;
    endfunction

    function automatic reading_t predict_reading(input logic [ptl_pkg::VIN_W-1:0] v_in);
        longint   v, r, first_uv, last_uv;
        int       lo, hi, mid;
        reading_t e;
        v        = longint'(v_in);
        first_uv = longint'(pt_mv[0]) * 1000;
        last_uv  = longint'(pt_mv[N_POINTS-1]) * 1000;
        if (v <= first_uv)
        begin
            // below the table, first segment slope, floor at 100 ohm
            r = seg_line(0, 1, v);
            if (r < longint'(ptl_pkg::R_MIN_CENTIOHM))
                r = longint'(ptl_pkg::R_MIN_CENTIOHM);
            e.flag = ptl_pkg::FLAG_BELOW;
        end
        else if (v >= last_uv)
        begin
            // above the table, last segment slope, ceiling at 2000 ohm
            r = seg_line(N_POINTS - 2, N_POINTS - 1, v);
            if (r > longint'(ptl_pkg::R_MAX_CENTIOHM))
                r = longint'(ptl_pkg::R_MAX_CENTIOHM);
            e.flag = ptl_pkg::FLAG_ABOVE;
        end
        else
        begin
            lo = 0;
            hi = N_POINTS - 1;
            while (hi - lo > 1)
            begin
                mid = lo + (hi - lo) / 2;
                if (v < longint'(pt_mv[mid]) * 1000)
                    hi = mid;
                else
                    lo = mid;
            end
            r = seg_line(lo, lo + 1, v);
            e.flag = ptl_pkg::FLAG_INSIDE;
        end
        if (r < 0)
            r = 0;
        if (r > 64'h3FFFF)
            r = 64'h3FFFF;
        e.res = r[ptl_pkg::RES_W-1:0];
        return e;
    endfunction

    function automatic logic [ptl_pkg::VIN_W-1:0] rand_voltage();
        int pick, idx;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return ptl_pkg::VIN_W'($urandom_range(15001, 2425999));
        if (pick < 75)
        begin
            // close to a calibration point, either side
            idx = $urandom_range(0, 30);
            return ptl_pkg::VIN_W'(pt_mv[idx] * 1000 + $urandom_range(0, 6) - 3);
        end
        if (pick < 85)
            return ptl_pkg::VIN_W'($urandom_range(0, 15000));
        if (pick < 95)
            return ptl_pkg::VIN_W'($urandom_range(2426000, 5000000));
        return ptl_pkg::VIN_W'($urandom_range(0, 8388607));
    endfunction

    // idle length, mostly short, a few long, none in quiet phases
    function automatic int rand_idle(input int count, input int long_max);
        int pick;
        if (((count / 128) % 4) == 2)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 5);
        return $urandom_range(15, long_max);
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    // sampling on the rising edge: check results, then log accepted items
    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_cnt++;
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("unexpected result res=%0d flag=%0d",
                                              resistance_centiohm, range_flag));
                else
                begin
                    e = expected_readings.pop_front();
                    if (resistance_centiohm !== e.res)
                        report_mismatch($sformatf("resistance %0d, wanted %0d",
                                                  resistance_centiohm, e.res));
                    if (range_flag !== e.flag)
                        report_mismatch($sformatf("range flag %0d, wanted %0d",
                                                  range_flag, e.flag));
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_readings.push_back(predict_reading(voltage_uv));
                in_acc_cnt++;
            end
        end
    end

    // item driver on the falling edge
    always @(negedge clk)
    begin
        logic nv;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            nv = in_valid;
            if (in_valid && in_acc_cnt != drv_seen_cnt)
            begin
                drv_seen_cnt = in_acc_cnt;
                nv = 1'b0;
                gap_left = rand_idle(in_acc_cnt, 80);
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_voltages.size() > 0)
                begin
                    voltage_uv <= pending_voltages.pop_front();
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // result receiver: random stalls plus two long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_idx < 2 && got_cnt >= hold_marks[hold_idx])
            begin
                hold_left = 400;
                hold_idx++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = rand_idle(got_cnt, 100);
            end
        end
    end

    initial
    begin
        // edges of the table, exact points, inputs past the ceiling clamp and every input bit
        pending_voltages.push_back(23'd0);
        pending_voltages.push_back(23'd1);
        pending_voltages.push_back(23'd14999);
        pending_voltages.push_back(23'd15000);
        pending_voltages.push_back(23'd15001);
        pending_voltages.push_back(23'd145000);
        pending_voltages.push_back(23'd1818000);
        pending_voltages.push_back(23'd1980999);
        pending_voltages.push_back(23'd1981000);
        pending_voltages.push_back(23'd1981001);
        pending_voltages.push_back(23'd2200999);
        pending_voltages.push_back(23'd2330000);
        pending_voltages.push_back(23'd2425999);
        pending_voltages.push_back(23'd2426000);
        pending_voltages.push_back(23'd2426001);
        pending_voltages.push_back(23'd3216342);
        pending_voltages.push_back(23'd3216343);
        pending_voltages.push_back(23'd4194304);
        pending_voltages.push_back(23'd5000000);
        pending_voltages.push_back(23'h2AAAAA);
        pending_voltages.push_back(23'h555555);
        pending_voltages.push_back(23'h7FFFFF);
        for (int i = 0; i < N_RANDOM; i++)
            pending_voltages.push_back(rand_voltage());

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_voltages.size() > 0 || in_valid || expected_readings.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_readings.size() > 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_readings.size()));

        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #12000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/ptl_pkg.sv
design/ptl_divider.sv
design/pt1000_piecewise_linearizer_core.sv
design/ptl_checker.sv
tb/tb_top.sv
